// ===== hdl/msadpcm_pkg.sv =====
package msadpcm_pkg;

  // Block geometry and defaults.
  localparam int STEP_WIDTH_DEF = 24;
  localparam int NUM_PAIRS      = 7;
  localparam int PAIR_IDX_W     = $clog2(NUM_PAIRS);
  localparam int HEADER_LEN     = 14;
  localparam int CMD_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;
  localparam int FREE_W         = $clog2(OUT_DEPTH + 1);
  localparam int CFG_ADDR_W     = $clog2(NUM_PAIRS) + 2;

  // Header positions with a meaning of their own.
  localparam logic [3:0] HDR_DONE       = 4'd0;
  localparam logic [3:0] HDR_RIGHT_PRED = 4'd1;
  localparam logic [3:0] HDR_STEP_L     = 4'd3;
  localparam logic [3:0] HDR_STEP_R     = 4'd5;
  localparam logic [3:0] HDR_PREV1_L    = 4'd7;
  localparam logic [3:0] HDR_PREV1_R    = 4'd9;
  localparam logic [3:0] HDR_PREV2_L    = 4'd11;
  localparam logic [3:0] HDR_LAST       = 4'(HEADER_LEN - 1);

  // Sample and step limits.
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int STEP_FLOOR = 16;

  // Reset values of the predictor pair registers.
  localparam logic [31:0] COEF_RESET [NUM_PAIRS] = '{
    32'd256, 32'd4278190592, 32'd0, 32'd4194496,
    32'd240, 32'd4281336268, 32'd4279763336
  };

  // Commands passed from the front to the back.
  typedef logic [2:0] op_t;
  localparam op_t OP_DATA          = 3'd0;
  localparam op_t OP_PRED_L        = 3'd1;
  localparam op_t OP_PRED_R        = 3'd2;
  localparam op_t OP_STEP          = 3'd3;
  localparam op_t OP_PREV_ONE      = 3'd4;
  localparam op_t OP_PREV_TWO      = 3'd5;
  localparam op_t OP_PREV_TWO_LAST = 3'd6;

  typedef struct packed {
    op_t         op;
    logic        ch;
    logic        bad;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               bad;
    logic               last;
  } result_t;

  // Results pushed into the output queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } res_push_t;

  // Step adaptation factor, scaled by 256.
  function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
    logic [9:0] f;
    case (nib)
      4'd4, 4'd12: f = 10'd307;
      4'd5, 4'd11: f = 10'd409;
      4'd6, 4'd10: f = 10'd512;
      4'd7, 4'd9:  f = 10'd614;
      4'd8:        f = 10'd768;
      default:     f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/stereo_ms_adpcm_block_decoder_core.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// input    | in        | push / full            | in_byte, block_start
// result   | out       | empty / pop            | left_sample, right_sample, bad_predictor,
//          |           |                        | last_of_run
// config   | in/out    | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// One input byte can be taken every cycle while the four-entry command queue has room.
// Header bytes that complete a field go to the back end as commands; a data byte passes
// through the predictor recurrence (product registers, then sum, clamp and state update).
// The last header byte pushes two results at once into the four-entry result queue.
// Reset (rst, synchronous) restores the predictor pairs and clears both queues.
// The back end waits while fewer than two result slots are free; the command queue then
// fills and full rises.
module stereo_ms_adpcm_block_decoder_core
  import msadpcm_pkg::*;
#(
  parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte,
  input  logic                  block_start,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [15:0]    left_sample,
  output logic signed [15:0]    right_sample,
  output logic                  bad_predictor,
  output logic                  last_of_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0]           coef_pair [NUM_PAIRS];
  logic [PAIR_IDX_W-1:0] cfg_idx;
  logic                  cfg_write;
  logic                  cmd_push;
  cmd_t                  cmd_in;
  cmd_t                  cmd_head;
  logic                  cmd_full;
  logic                  cmd_empty;
  logic                  cmd_pop;
  logic [FREE_W-1:0]     out_free;
  res_push_t             res_push;
  result_t               head;

  // Configuration registers: predictor pairs.
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAIRS; i++) coef_pair[i] <= COEF_RESET[i];
    end else if (cfg_write && (cfg_idx < PAIR_IDX_W'(NUM_PAIRS))) begin
      coef_pair[cfg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (cfg_idx < PAIR_IDX_W'(NUM_PAIRS)) prdata = coef_pair[cfg_idx];
  end

  // Front end: header tracking and command building.
  msadpcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_byte     (in_byte),
    .block_start (block_start),
    .cmd_full    (cmd_full),
    .coef_pair   (coef_pair),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  assign full = cmd_full;

  msadpcm_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .cmd_in  (cmd_in),
    .pop     (cmd_pop),
    .cmd_out (cmd_head),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  // Back end: channel state and sample decode.
  msadpcm_back #(
    .STEP_WIDTH (STEP_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_free  (out_free),
    .res_push  (res_push)
  );

  msadpcm_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .free     (out_free)
  );

  assign left_sample   = head.left_sample;
  assign right_sample  = head.right_sample;
  assign bad_predictor = head.bad;
  assign last_of_run   = head.last;

endmodule

// ===== hdl/msadpcm_front.sv =====
module msadpcm_front
  import msadpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  in_byte,
  input  logic        block_start,
  input  logic        cmd_full,
  input  logic [31:0] coef_pair [NUM_PAIRS],
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [3:0]            hdr_pos;
  logic [3:0]            hdr_pos_next;
  logic [7:0]            held_byte;
  logic [7:0]            held_byte_next;
  logic                  accept;
  logic                  has_cmd;
  logic                  bad_idx;
  logic [PAIR_IDX_W-1:0] pair_sel;
  logic [15:0]           word;

  assign accept = push && !cmd_full;

  // Predictor index lookup; an out-of-range index falls back to the last pair.
  assign bad_idx  = in_byte > 8'(NUM_PAIRS - 1);
  assign pair_sel = bad_idx ? PAIR_IDX_W'(NUM_PAIRS - 1) : in_byte[PAIR_IDX_W-1:0];
  assign word     = {in_byte, held_byte};

  // Classify the byte by its place in the block.
  always_comb begin
    hdr_pos_next   = hdr_pos;
    held_byte_next = held_byte;
    has_cmd        = 1'b0;
    cmd.op         = OP_DATA;
    cmd.ch         = 1'b0;
    cmd.bad        = 1'b0;
    cmd.data       = {24'd0, in_byte};
    if (block_start) begin
      has_cmd      = 1'b1;
      cmd.op       = OP_PRED_L;
      cmd.bad      = bad_idx;
      cmd.data     = coef_pair[pair_sel];
      hdr_pos_next = HDR_RIGHT_PRED;
    end else if (hdr_pos == HDR_DONE) begin
      has_cmd = 1'b1;
    end else if (hdr_pos == HDR_RIGHT_PRED) begin
      has_cmd      = 1'b1;
      cmd.op       = OP_PRED_R;
      cmd.ch       = 1'b1;
      cmd.bad      = bad_idx;
      cmd.data     = coef_pair[pair_sel];
      hdr_pos_next = hdr_pos + 4'd1;
    end else if (!hdr_pos[0]) begin
      held_byte_next = in_byte;
      hdr_pos_next   = hdr_pos + 4'd1;
    end else begin
      has_cmd  = 1'b1;
      cmd.data = {16'd0, word};
      case (hdr_pos)
        HDR_STEP_L: begin
          cmd.op = OP_STEP;
        end
        HDR_STEP_R: begin
          cmd.op = OP_STEP;
          cmd.ch = 1'b1;
        end
        HDR_PREV1_L: begin
          cmd.op = OP_PREV_ONE;
        end
        HDR_PREV1_R: begin
          cmd.op = OP_PREV_ONE;
          cmd.ch = 1'b1;
        end
        HDR_PREV2_L: begin
          cmd.op = OP_PREV_TWO;
        end
        default: begin
          cmd.op = OP_PREV_TWO_LAST;
          cmd.ch = 1'b1;
        end
      endcase
      hdr_pos_next = (hdr_pos >= HDR_LAST) ? HDR_DONE : hdr_pos + 4'd1;
    end
  end

  assign cmd_push = accept && has_cmd;

  // Header tracking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos   <= HDR_DONE;
      held_byte <= 8'd0;
    end else if (accept) begin
      hdr_pos   <= hdr_pos_next;
      held_byte <= held_byte_next;
    end
  end

  // The header position never runs past the last header byte.
  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    hdr_pos <= HDR_LAST)
    else $error("header position out of range");

endmodule

// ===== hdl/msadpcm_cmd_queue.sv =====
module msadpcm_cmd_queue
  import msadpcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t cmd_out,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(CMD_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= cmd_in;
  end

endmodule

// ===== hdl/msadpcm_back.sv =====
module msadpcm_back
  import msadpcm_pkg::*;
#(
  parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic [FREE_W-1:0] out_free,
  output res_push_t         res_push
);

  localparam int SW    = STEP_WIDTH;
  localparam int PS_W  = SW + 10;
  localparam int PC_W  = SW + 5;
  localparam int NS_W  = PS_W - 8;
  localparam int SUM_W = ((SW + 5) > 25 ? (SW + 5) : 25) + 1;
  localparam logic [SW-1:0] STEP_MAX = '1;
  localparam logic [SW-1:0] STEP_MIN = SW'(STEP_FLOOR);

  // Channel state.
  logic signed [15:0] coef_first  [2];
  logic signed [15:0] coef_second [2];
  logic signed [15:0] prev_one    [2];
  logic signed [15:0] prev_two    [2];
  logic [SW-1:0]      step        [2];
  logic               err;
  logic               busy;

  // Product stage.
  logic [3:0]             nib  [2];
  logic signed [31:0]     pa_c [2];
  logic signed [31:0]     pb_c [2];
  logic signed [PC_W-1:0] pc_c [2];
  logic [PS_W-1:0]        ps_c [2];
  logic signed [31:0]     pa_r [2];
  logic signed [31:0]     pb_r [2];
  logic signed [PC_W-1:0] pc_r [2];
  logic [PS_W-1:0]        ps_r [2];

  // Sum and clamp stage.
  logic signed [32:0]      sum      [2];
  logic signed [24:0]      pred     [2];
  logic signed [SUM_W-1:0] s        [2];
  logic [NS_W-1:0]         ns       [2];
  logic signed [15:0]      new_samp [2];
  logic [SW-1:0]           new_step [2];

  logic issue;
  logic issue_data;

  // Take a command only when no decode is in flight and two result slots are free.
  assign issue      = cmd_valid && !busy && (out_free >= FREE_W'(2));
  assign issue_data = issue && (cmd.op == OP_DATA);
  assign cmd_pop    = issue;

  // Products of the predictor and the step adaptation, both channels.
  always_comb begin
    nib[0] = cmd.data[7:4];
    nib[1] = cmd.data[3:0];
    for (int ch = 0; ch < 2; ch++) begin
      pa_c[ch] = prev_one[ch] * coef_first[ch];
      pb_c[ch] = prev_two[ch] * coef_second[ch];
      pc_c[ch] = $signed(nib[ch]) * $signed({1'b0, step[ch]});
      ps_c[ch] = PS_W'(adapt_factor(nib[ch])) * PS_W'(step[ch]);
    end
  end

  // Prediction, clamp and new step.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      sum[ch]  = 33'(pa_r[ch]) + 33'(pb_r[ch]);
      pred[ch] = sum[ch][32:8];
      s[ch]    = SUM_W'(pc_r[ch]) + SUM_W'(pred[ch]);
      if (s[ch] > SUM_W'(SAMPLE_MAX)) begin
        new_samp[ch] = 16'sh7fff;
      end else if (s[ch] < SUM_W'(SAMPLE_MIN)) begin
        new_samp[ch] = -16'sh8000;
      end else begin
        new_samp[ch] = s[ch][15:0];
      end
      ns[ch] = ps_r[ch][PS_W-1:8];
      if (|ns[ch][NS_W-1:SW]) begin
        new_step[ch] = STEP_MAX;
      end else if (ns[ch][SW-1:0] < STEP_MIN) begin
        new_step[ch] = STEP_MIN;
      end else begin
        new_step[ch] = ns[ch][SW-1:0];
      end
    end
  end

  // Results toward the output queue.
  always_comb begin
    res_push        = '0;
    res_push.first  = '{left_sample: new_samp[0], right_sample: new_samp[1],
                        bad: err, last: 1'b1};
    res_push.second = '{left_sample: prev_one[0], right_sample: prev_one[1],
                        bad: err, last: 1'b1};
    if (busy) begin
      res_push.n = 2'd1;
    end else if (issue && (cmd.op == OP_PREV_TWO_LAST)) begin
      res_push.n     = 2'd2;
      res_push.first = '{left_sample: prev_two[0], right_sample: cmd.data[15:0],
                         bad: err, last: 1'b0};
    end
  end

  // Product registers carry no reset.
  always_ff @(posedge clk) begin
    if (issue_data) begin
      pa_r <= pa_c;
      pb_r <= pb_c;
      pc_r <= pc_c;
      ps_r <= ps_c;
    end
  end

  // Channel state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      err  <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        coef_first[ch]  <= '0;
        coef_second[ch] <= '0;
        prev_one[ch]    <= '0;
        prev_two[ch]    <= '0;
        step[ch]        <= STEP_MIN;
      end
    end else begin
      busy <= issue_data;
      if (busy) begin
        for (int ch = 0; ch < 2; ch++) begin
          step[ch]     <= new_step[ch];
          prev_two[ch] <= prev_one[ch];
          prev_one[ch] <= new_samp[ch];
        end
      end
      if (issue) begin
        case (cmd.op)
          OP_PRED_L: begin
            err            <= cmd.bad;
            coef_first[0]  <= cmd.data[15:0];
            coef_second[0] <= cmd.data[31:16];
          end
          OP_PRED_R: begin
            err            <= err || cmd.bad;
            coef_first[1]  <= cmd.data[15:0];
            coef_second[1] <= cmd.data[31:16];
          end
          OP_STEP: begin
            step[cmd.ch] <= SW'(cmd.data[15:0]);
          end
          OP_PREV_ONE: begin
            prev_one[cmd.ch] <= cmd.data[15:0];
          end
          OP_PREV_TWO, OP_PREV_TWO_LAST: begin
            prev_two[cmd.ch] <= cmd.data[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // A data byte yields exactly one result in the cycle after it is taken.
  a_data_one_result: assert property (@(posedge clk) disable iff (rst)
    issue_data |=> (res_push.n == 2'd1))
    else $error("data byte did not produce one result");

  // An adapted step never drops below the floor.
  a_step_floor: assert property (@(posedge clk) disable iff (rst)
    busy |=> (step[0] >= STEP_MIN) && (step[1] >= STEP_MIN))
    else $error("adapted step below floor");

endmodule

// ===== hdl/msadpcm_out_queue.sv =====
module msadpcm_out_queue
  import msadpcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  res_push_t         res_push,
  input  logic              pop,
  output result_t           head,
  output logic              empty,
  output logic [FREE_W-1:0] free
);

  localparam int PTR_W = $clog2(OUT_DEPTH);

  result_t           slots [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FREE_W-1:0] count;
  logic              do_pop;

  assign empty  = count == '0;
  assign free   = FREE_W'(OUT_DEPTH) - count;
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  // Pointers and fill count; up to two results enter per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(res_push.n);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + FREE_W'(res_push.n) - FREE_W'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (res_push.n != 2'd0) slots[wr_ptr] <= res_push.first;
    if (res_push.n == 2'd2) slots[wr_ptr + PTR_W'(1)] <= res_push.second;
  end

  // The back end only pushes what fits.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    FREE_W'(res_push.n) <= free)
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FREE_W'(OUT_DEPTH))
    else $error("result queue count out of range");

endmodule

// ===== test/stereo_ms_adpcm_decode_checker.sv =====
module stereo_ms_adpcm_decode_checker
  import msadpcm_pkg::*;
#(
  parameter int STEP_W = STEP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic [7:0]            in_byte,
  input  logic                  block_start,
  input  logic                  empty,
  input  logic                  pop,
  input  logic signed [15:0]    left_sample,
  input  logic signed [15:0]    right_sample,
  input  logic                  bad_predictor,
  input  logic                  last_of_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 200;
  localparam longint STEP_TOP = (longint'(1) << STEP_W) - 1;

  // Step growth per nibble code, in 1/256 units.
  localparam int GAIN [16] = '{
    230, 230, 230, 230, 307, 409, 512, 614,
    768, 614, 512, 409, 307, 230, 230, 230
  };

  // Shadow of the predictor pair registers and of the decoder state.
  logic [31:0]        pair_reg [NUM_PAIRS];
  logic [3:0]         hdr_pos;
  logic [7:0]         low_hold;
  logic signed [15:0] coef_a [2];
  logic signed [15:0] coef_b [2];
  logic signed [15:0] hist_new [2];
  logic signed [15:0] hist_old [2];
  logic [STEP_W-1:0]  ch_step [2];
  logic               bad_seen;

  // Stereo pairs predicted but not yet seen on the result side.
  result_t pairs_due [$];

  // Selects the coefficients of one channel; an index past the table takes the last pair.
  function automatic void load_pair(input int ch, input logic [7:0] idx);
    int sel;
    sel = int'(idx);
    if (sel > NUM_PAIRS - 1) begin
      sel = NUM_PAIRS - 1;
      bad_seen = 1'b1;
    end
    coef_a[ch] = pair_reg[sel][15:0];
    coef_b[ch] = pair_reg[sel][31:16];
  endfunction

  // Decodes one nibble of one channel and advances its step and history.
  function automatic logic signed [15:0] decode_nibble(input int ch, input logic [3:0] nib);
    longint st;
    longint grown;
    longint guess;
    longint sum;
    st = ch_step[ch];
    grown = (GAIN[nib] * st) >>> 8;
    if (grown < STEP_FLOOR) grown = longint'(STEP_FLOOR);
    if (grown > STEP_TOP) grown = STEP_TOP;
    ch_step[ch] = grown[STEP_W-1:0];
    guess = (longint'(hist_new[ch]) * longint'(coef_a[ch]) +
             longint'(hist_old[ch]) * longint'(coef_b[ch])) >>> 8;
    sum = longint'(signed'(nib)) * st + guess;
    if (sum > SAMPLE_MAX) sum = longint'(SAMPLE_MAX);
    else if (sum < SAMPLE_MIN) sum = longint'(SAMPLE_MIN);
    hist_old[ch] = hist_new[ch];
    hist_new[ch] = sum[15:0];
    return hist_new[ch];
  endfunction

  function automatic void expect_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                                      input logic fin);
    result_t one;
    one.left_sample  = l;
    one.right_sample = r;
    one.bad          = bad_seen;
    one.last         = fin;
    pairs_due.push_back(one);
  endfunction

  function automatic void note_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : track
    result_t            due;
    logic signed [15:0] left_val;
    logic signed [15:0] right_val;
    logic [15:0]        word;
    if (rst) begin
      for (int i = 0; i < NUM_PAIRS; i++) pair_reg[i] = COEF_RESET[i];
      hdr_pos  = HDR_DONE;
      low_hold = '0;
      bad_seen = 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        coef_a[ch]   = '0;
        coef_b[ch]   = '0;
        ch_step[ch]  = STEP_W'(STEP_FLOOR);
        hist_new[ch] = '0;
        hist_old[ch] = '0;
      end
      pairs_due.delete();
      mismatches = 0;
    end else begin
      // Compare each result transaction with the oldest prediction.
      if (pop && !empty) begin
        if (pairs_due.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $error("result with nothing expected: left_sample %0d, right_sample %0d",
                   left_sample, right_sample);
          mismatches++;
        end else begin
          due = pairs_due.pop_front();
          note_field("left_sample", due.left_sample, left_sample);
          note_field("right_sample", due.right_sample, right_sample);
          note_field("bad_predictor", due.bad, bad_predictor);
          note_field("last_of_run", due.last, last_of_run);
        end
      end

      // Track register writes on the configuration port.
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] < NUM_PAIRS)
        pair_reg[paddr[CFG_ADDR_W-1:2]] = pwdata;

      // Run each input transaction through the decoder shadow.
      if (push && !full) begin
        if (block_start) begin
          bad_seen = 1'b0;
          load_pair(0, in_byte);
          hdr_pos = HDR_RIGHT_PRED;
        end else if (hdr_pos == HDR_DONE) begin
          left_val  = decode_nibble(0, in_byte[7:4]);
          right_val = decode_nibble(1, in_byte[3:0]);
          expect_pair(left_val, right_val, 1'b1);
        end else if (hdr_pos == HDR_RIGHT_PRED) begin
          load_pair(1, in_byte);
          hdr_pos = hdr_pos + 4'd1;
        end else if (!hdr_pos[0]) begin
          low_hold = in_byte;
          hdr_pos  = hdr_pos + 4'd1;
        end else begin
          word = {in_byte, low_hold};
          case (hdr_pos)
            HDR_STEP_L:  ch_step[0]  = STEP_W'(word);
            HDR_STEP_R:  ch_step[1]  = STEP_W'(word);
            HDR_PREV1_L: hist_new[0] = word;
            HDR_PREV1_R: hist_new[1] = word;
            HDR_PREV2_L: hist_old[0] = word;
            default:     hist_old[1] = word;
          endcase
          if (hdr_pos == HDR_LAST) begin
            hdr_pos = HDR_DONE;
            expect_pair(hist_old[0], hist_old[1], 1'b0);
            expect_pair(hist_new[0], hist_new[1], 1'b1);
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
      end
    end
    pending = pairs_due.size();
  end

endmodule

// ===== test/stereo_ms_adpcm_block_decoder_core_test.sv =====
module stereo_ms_adpcm_block_decoder_core_test
  import msadpcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_W      = STEP_WIDTH_DEF;
  localparam int PHASE_ITEMS = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 24;

  // Coefficient settings with fields at the extremes, at zero, at minus one and at plus and minus 256.
  localparam logic [31:0] EDGE_PAIRS [NUM_PAIRS] = '{
    32'h7FFF_7FFF, 32'h8000_8000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h8000_7FFF, 32'h7FFF_8000, 32'h0100_FF00
  };

  typedef enum {PAIRS_EXTREME, PAIRS_RANDOM, PAIRS_DEFAULT} pair_set_e;
  typedef enum {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_SPARSE} drain_e;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic [7:0]            in_byte;
  logic                  block_start;
  logic                  empty;
  logic                  pop;
  logic signed [15:0]    left_sample;
  logic signed [15:0]    right_sample;
  logic                  bad_predictor;
  logic                  last_of_run;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    mismatches;
  int                    pending;
  int                    items_sent;
  int                    burst_left;
  int                    quiet_cycles;

  stereo_ms_adpcm_block_decoder_core #(
    .STEP_WIDTH(STEP_W)
  ) i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_byte(in_byte), .block_start(block_start),
    .empty(empty), .pop(pop), .left_sample(left_sample), .right_sample(right_sample),
    .bad_predictor(bad_predictor), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stereo_ms_adpcm_decode_checker #(
    .STEP_W(STEP_W)
  ) i_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_byte(in_byte), .block_start(block_start),
    .empty(empty), .pop(pop), .left_sample(left_sample), .right_sample(right_sample),
    .bad_predictor(bad_predictor), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one byte and returns at the falling edge after its transaction.
  // Bytes go out in bursts of random length with random gaps in between.
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    push        <= 1'b1;
    in_byte     <= b;
    block_start <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_header(input logic [7:0] idx_l, input logic [7:0] idx_r,
                             input logic [15:0] step_l, input logic [15:0] step_r,
                             input logic [15:0] new_l, input logic [15:0] new_r,
                             input logic [15:0] old_l, input logic [15:0] old_r);
    logic [15:0] words [6];
    words = '{step_l, step_r, new_l, new_r, old_l, old_r};
    send_byte(idx_l, 1'b1);
    send_byte(idx_r, 1'b0);
    foreach (words[k]) begin
      send_byte(words[k][7:0], 1'b0);
      send_byte(words[k][15:8], 1'b0);
    end
  endtask

  // Mostly valid predictor indices, now and then one past the table.
  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(7, 255));
    return 8'($urandom_range(0, NUM_PAIRS - 1));
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 64));
      1:       return 16'($urandom);
      default: return 16'($urandom_range(16, 4095));
    endcase
  endfunction

  // One block: optional noise, optional broken header, a full header, then data.
  task automatic random_block();
    int cut;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(3, 16)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, 13);
      send_byte(8'($urandom), 1'b1);
      repeat (cut - 1) send_byte(8'($urandom), 1'b0);
    end
    send_header(pick_index(), pick_index(), pick_step(), pick_step(),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    repeat ($urandom_range(0, 24)) send_byte(8'($urandom), 1'b0);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_pair(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx << 2);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Waits until the block is idle, then loads a new coefficient setting.
  task automatic reprogram(input pair_set_e set);
    logic [31:0] value;
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    for (int i = 0; i < NUM_PAIRS; i++) begin
      case (set)
        PAIRS_EXTREME: value = EDGE_PAIRS[i];
        PAIRS_RANDOM:  value = $urandom;
        default:       value = COEF_RESET[i];
      endcase
      write_pair(i, value);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main stimulus and verdict.
  initial begin : feed
    int goal;
    rst         = 1'b1;
    push        = 1'b0;
    in_byte     = '0;
    block_start = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    items_sent  = 0;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Data before any header decodes from the reset state.
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    // A header cut short by a new block start.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // Both predictor indices out of range, header steps at their extremes,
    // history at full scale.
    send_header(8'hFF, 8'h07, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    // Largest growth factor until the left step saturates.
    repeat (6) send_byte(8'h88, 1'b0);

    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) random_block();
    for (int s = PAIRS_EXTREME; s <= PAIRS_DEFAULT; s++) begin
      reprogram(pair_set_e'(s));
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_block();
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: a long hold-off first so that both queues fill, then
  // stretches of free flow, choppy and sparse popping.
  initial begin : drain_side
    drain_e mode;
    int     span;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
    forever begin
      mode = drain_e'($urandom_range(0, 2));
      span = $urandom_range(10, 80);
      repeat (span) begin
        case (mode)
          DRAIN_FREE:   pop <= 1'b1;
          DRAIN_CHOPPY: pop <= $urandom_range(0, 2) != 0;
          default:      pop <= $urandom_range(0, 4) == 0;
        endcase
        @(negedge clk);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
